// File: design/ssi_rd_pkg.sv
// shared types and constants for the ssi encoder reader
// no dependencies; used by ssi_rd_core and ssi_encoder_reader_unit
`default_nettype none

package ssi_rd_pkg;

   // default width of the turns and position shift registers
   localparam int FIELD_WIDTH_DEFAULT = 16;
   // width of the turns and position result fields
   localparam int VALUE_WIDTH = 16;
   // status field width and largest status bit count
   localparam int STATUS_WIDTH = 8;
   localparam int STATUS_MAX = 8;

   // configuration register port
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TURN_BITS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POSITION_BITS = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STATUS_COUNT = 2'd2;

   // configuration reset values
   localparam logic [4:0] TURN_BITS_RESET = 5'd12;
   localparam logic [4:0] POSITION_BITS_RESET = 5'd13;
   localparam logic [3:0] STATUS_COUNT_RESET = 4'd0;

   // request kinds
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_START = 1'b1;

   // one result transfer
   typedef struct packed {
      logic                    clock_level;
      logic                    busy_res;
      logic                    done_res;
      logic [VALUE_WIDTH-1:0]  turns;
      logic [VALUE_WIDTH-1:0]  position;
      logic [STATUS_WIDTH-1:0] status_value;
   } result_type;

endpackage

`default_nettype wire

// File: design/ssi_rd_core.sv
// ssi frame sequencer: config registers, frame state and result formation
// depends on ssi_rd_pkg
`default_nettype none

module ssi_rd_core #(
   parameter int FIELD_WIDTH = ssi_rd_pkg::FIELD_WIDTH_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    accept,
   input  wire logic                                    kind,
   input  wire logic                                    data_level,
   input  wire logic                                    gray_mode,
   input  wire logic                                    csr_write_enable,
   input  wire logic [ssi_rd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [ssi_rd_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   output ssi_rd_pkg::result_type                       result
);

   localparam int VW = ssi_rd_pkg::VALUE_WIDTH;
   localparam int SW = ssi_rd_pkg::STATUS_WIDTH;
   // bit counter wide enough for the largest frame length
   localparam int CW = $clog2(2 * FIELD_WIDTH + ssi_rd_pkg::STATUS_MAX + 1);

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_LEAD   = 4'b0010,
      PH_LOW    = 4'b0100,
      PH_SAMPLE = 4'b1000
   } phase_type;

   logic [4:0]             turn_bits_ff;
   logic [4:0]             position_bits_ff;
   logic [3:0]             status_count_ff;

   phase_type              phase_ff, phase_in;
   logic [CW-1:0]          bit_index_ff, bit_index_in;
   logic [FIELD_WIDTH-1:0] turn_shift_ff, turn_shift_in;
   logic [FIELD_WIDTH-1:0] position_shift_ff, position_shift_in;
   logic [SW-1:0]          status_shift_ff, status_shift_in;
   logic                   gray_latched_ff, gray_latched_in;
   logic                   clock_out_ff, clock_out_in;

   logic [CW-1:0]          t_cnt, p_cnt, s_cnt, tp_cnt, total_cnt;
   logic [CW-1:0]          index_next;
   logic                   done;
   logic [FIELD_WIDTH-1:0] turn_bin, position_bin;
   logic [FIELD_WIDTH-1:0] turn_val, position_val;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         turn_bits_ff     <= ssi_rd_pkg::TURN_BITS_RESET;
         position_bits_ff <= ssi_rd_pkg::POSITION_BITS_RESET;
         status_count_ff  <= ssi_rd_pkg::STATUS_COUNT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ssi_rd_pkg::CSR_TURN_BITS:     turn_bits_ff     <= csr_write_data;
            ssi_rd_pkg::CSR_POSITION_BITS: position_bits_ff <= csr_write_data;
            ssi_rd_pkg::CSR_STATUS_COUNT:  status_count_ff  <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   // clamped bit counts and field boundaries
   always_comb begin
      t_cnt = (CW'(turn_bits_ff) > CW'(FIELD_WIDTH)) ? CW'(FIELD_WIDTH)
                                                     : CW'(turn_bits_ff);
      p_cnt = (CW'(position_bits_ff) > CW'(FIELD_WIDTH)) ? CW'(FIELD_WIDTH)
                                                         : CW'(position_bits_ff);
      s_cnt = (CW'(status_count_ff) > CW'(ssi_rd_pkg::STATUS_MAX))
              ? CW'(ssi_rd_pkg::STATUS_MAX) : CW'(status_count_ff);
      tp_cnt    = t_cnt + p_cnt;
      total_cnt = tp_cnt + s_cnt;
   end

   // frame sequencing
   always_comb begin
      phase_in          = phase_ff;
      bit_index_in      = bit_index_ff;
      turn_shift_in     = turn_shift_ff;
      position_shift_in = position_shift_ff;
      status_shift_in   = status_shift_ff;
      gray_latched_in   = gray_latched_ff;
      clock_out_in      = clock_out_ff;
      index_next        = bit_index_ff;
      done              = 1'b0;

      if (kind == ssi_rd_pkg::KIND_START) begin
         if (phase_ff == PH_IDLE) begin
            gray_latched_in   = gray_mode;
            turn_shift_in     = '0;
            position_shift_in = '0;
            status_shift_in   = '0;
            bit_index_in      = '0;
            clock_out_in      = 1'b0;
            phase_in          = PH_LEAD;
         end
      end else begin
         unique case (phase_ff)
            PH_LEAD: begin
               clock_out_in = 1'b1;
               if (total_cnt == '0) begin
                  done = 1'b1;
               end else begin
                  phase_in = PH_LOW;
               end
            end
            PH_LOW: begin
               clock_out_in = 1'b0;
               phase_in     = PH_SAMPLE;
            end
            PH_SAMPLE: begin
               // shift the sampled bit into the field that owns this index
               if (bit_index_ff < t_cnt) begin
                  turn_shift_in = {turn_shift_ff[FIELD_WIDTH-2:0], data_level};
               end else if (bit_index_ff < tp_cnt) begin
                  position_shift_in = {position_shift_ff[FIELD_WIDTH-2:0], data_level};
               end else if (bit_index_ff < total_cnt) begin
                  status_shift_in = {status_shift_ff[SW-2:0], data_level};
               end
               if (bit_index_ff < total_cnt) begin
                  index_next = bit_index_ff + CW'(1);
               end
               bit_index_in = index_next;
               clock_out_in = 1'b1;
               if (index_next >= total_cnt) begin
                  done = 1'b1;
               end else begin
                  phase_in = PH_LOW;
               end
            end
            default: begin
               clock_out_in = 1'b1;
            end
         endcase
      end

      if (done) begin
         phase_in     = PH_IDLE;
         bit_index_in = '0;
      end
   end

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         bit_index_ff      <= '0;
         turn_shift_ff     <= '0;
         position_shift_ff <= '0;
         status_shift_ff   <= '0;
         gray_latched_ff   <= 1'b0;
         clock_out_ff      <= 1'b1;
      end else if (accept) begin
         phase_ff          <= phase_in;
         bit_index_ff      <= bit_index_in;
         turn_shift_ff     <= turn_shift_in;
         position_shift_ff <= position_shift_in;
         status_shift_ff   <= status_shift_in;
         gray_latched_ff   <= gray_latched_in;
         clock_out_ff      <= clock_out_in;
      end
   end

   // gray to binary: each bit is the xor of itself and all higher bits
   always_comb begin
      for (int i = 0; i < FIELD_WIDTH; i++) begin
         turn_bin[i]     = ^(turn_shift_in >> i);
         position_bin[i] = ^(position_shift_in >> i);
      end
      turn_val     = gray_latched_in ? turn_bin : turn_shift_in;
      position_val = gray_latched_in ? position_bin : position_shift_in;
   end

   // result of the current transfer; values only on the completing tick
   always_comb begin
      result.clock_level  = clock_out_in;
      result.busy_res     = (phase_in != PH_IDLE);
      result.done_res     = done;
      result.turns        = done ? VW'(turn_val) : '0;
      result.position     = done ? VW'(position_val) : '0;
      result.status_value = done ? status_shift_in : '0;
   end

endmodule

`default_nettype wire

// File: design/ssi_encoder_reader_unit.sv
// ssi absolute encoder reader top level; depends on ssi_rd_pkg and ssi_rd_core
// a response is registered in the output register, or in the skid register while rsp_stall holds the output
// throughput: one request per cycle while req_stall is low, each one half period of the ssi clock
// a response held by rsp_stall waits in the output register, one more request
// lands in the skid register, then req_stall holds off further requests
// reset: synchronous; frame idle, clock line high, config 12/13/0 bits, buffer empty
`default_nettype none

module ssi_encoder_reader_unit #(
   parameter int FIELD_WIDTH = ssi_rd_pkg::FIELD_WIDTH_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // request channel
   input  wire logic                                    req_valid,
   output      logic                                    req_stall,
   input  wire logic                                    req_kind,
   input  wire logic                                    req_data_level,
   input  wire logic                                    req_gray_mode,
   // response channel
   output      logic                                    rsp_valid,
   input  wire logic                                    rsp_stall,
   output      logic                                    rsp_clock_level,
   output      logic                                    rsp_busy_res,
   output      logic                                    rsp_done_res,
   output      logic [ssi_rd_pkg::VALUE_WIDTH-1:0]      rsp_turns,
   output      logic [ssi_rd_pkg::VALUE_WIDTH-1:0]      rsp_position,
   output      logic [ssi_rd_pkg::STATUS_WIDTH-1:0]     rsp_status_value,
   // configuration writes
   input  wire logic                                    csr_write_enable,
   input  wire logic [ssi_rd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [ssi_rd_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);

   logic                   req_accept;
   logic                   rsp_take;
   ssi_rd_pkg::result_type new_result;
   ssi_rd_pkg::result_type out_data_ff;
   ssi_rd_pkg::result_type skid_data_ff;
   logic                   out_valid_ff;
   logic                   skid_valid_ff;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = out_valid_ff && !rsp_stall;

   ssi_rd_core #(
      .FIELD_WIDTH(FIELD_WIDTH)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .accept           (req_accept),
      .kind             (req_kind),
      .data_level       (req_data_level),
      .gray_mode        (req_gray_mode),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .result           (new_result)
   );

   // output buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= req_accept;
         end
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // output buffer payload
   always_ff @(posedge clock) begin
      if (rsp_take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
         end else if (req_accept) begin
            out_data_ff <= new_result;
         end
      end else if (req_accept) begin
         skid_data_ff <= new_result;
      end
   end

   // response ports
   assign rsp_valid        = out_valid_ff;
   assign rsp_clock_level  = out_data_ff.clock_level;
   assign rsp_busy_res     = out_data_ff.busy_res;
   assign rsp_done_res     = out_data_ff.done_res;
   assign rsp_turns        = out_data_ff.turns;
   assign rsp_position     = out_data_ff.position;
   assign rsp_status_value = out_data_ff.status_value;

endmodule

`default_nettype wire
